FILE: hdl/bres_pkg.sv
// Shared types and constants for the block resequencer.
// No dependencies; used by the interfaces, bres_cfg and block_resequencer_core.
package bres_pkg;

  localparam int unsigned WINDOW = 16;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned PAY_W  = 64;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [ID_W-1:0] OWN_SYS_RST  = 8'd190;
  localparam logic [ID_W-1:0] OWN_COMP_RST = 8'd197;

  typedef enum logic [1:0] {
    KIND_STORED  = 2'd0,
    KIND_DUP     = 2'd1,
    KIND_DROPPED = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACK,
    S_REL
  } state_e;

  typedef enum logic {
    REG_OWN_SYS  = 1'b0,
    REG_OWN_COMP = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ID_W-1:0] own_sys;
    logic [ID_W-1:0] own_comp;
  } cfg_t;

endpackage

FILE: hdl/bres_if.sv
// Valid/ready channel interfaces for incoming blocks and for results.
// Depends on bres_pkg.
interface bres_in_if;
  import bres_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ID_W-1:0]       dst_system;
  logic [ID_W-1:0]       dst_component;
  logic [SEQ_W-1:0]      sequence_req;
  logic [PAY_W-1:0]      payload;

  modport source (output valid, dst_system, dst_component, sequence_req, payload,
                  input ready);
  modport sink   (input valid, dst_system, dst_component, sequence_req, payload,
                  output ready);
endinterface

interface bres_out_if;
  import bres_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [SEQ_W-1:0]      sequence_res;
  logic [PAY_W-1:0]      payload_res;
  logic                  last;

  modport source (output valid, kind, sequence_res, payload_res, last, input ready);
  modport sink   (input valid, kind, sequence_res, payload_res, last, output ready);
endinterface

FILE: hdl/block_resequencer_core.sv
// Block resequencer top level: intake check, payload memory, release sequencer.
// Depends on bres_pkg, bres_in_if, bres_out_if and bres_cfg.
//
// Usage: blocks enter on in_i (valid/ready) with target pair, sequence number and
// payload. A block whose target pair differs from the own pair registers is
// consumed silently. Any other block yields one acknowledgement on out_o (stored,
// duplicate or dropped beyond the 16-entry window), followed by every held block
// from the expected sequence number onward, in order, as release results. The
// final result of each block has last set.
// Timing: the acknowledgement is registered at the accept edge, then loaded into
// the output register from S_ACK, each release from S_REL. A block holds the
// sequencer until all its results are loaded, one at a time, by the single payload
// memory read port and one-entry output register. A new block is taken as soon
// as the final result sits in the output register, even if it is not yet taken.
// When the receiver stalls, the sequencer holds and the output register holds its
// result. Reset clears the expected number and all held flags at once (no clearing
// pass); the own pair registers reset to 190/197 and are written over APB.
module block_resequencer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bres_in_if.sink                     in_i,
  bres_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bres_pkg::APB_AW-1:0] paddr,
  input  logic [bres_pkg::APB_DW-1:0] pwdata,
  output logic [bres_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import bres_pkg::*;

  cfg_t              cfg;
  state_e            state_q, state_d;
  logic [SEQ_W-1:0]  ne_q, ne_d;
  logic [WINDOW-1:0] valid_q, valid_d;
  logic [PAY_W-1:0]  mem [WINDOW];
  logic [PAY_W-1:0]  rd_q;

  kind_e             ack_kind_q, ack_kind_d;
  logic [SEQ_W-1:0]  ack_seq_q;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q;
  logic [SEQ_W-1:0]  out_seq_q;
  logic [PAY_W-1:0]  out_pay_q;
  logic              out_last_q;

  logic              accept, match, store_en, out_free, ack_fire, rel_fire;
  logic [SEQ_W-1:0]  diff;
  logic [SLOT_W-1:0] in_slot, ne_slot, nx_slot;

  bres_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_slot = in_i.sequence_req[SLOT_W-1:0];
  assign ne_slot = ne_q[SLOT_W-1:0];
  assign nx_slot = ne_slot + SLOT_W'(1);
  assign diff    = in_i.sequence_req - ne_q;
  assign match   = (in_i.dst_system == cfg.own_sys) &&
                   (in_i.dst_component == cfg.own_comp);
  assign accept  = in_i.valid & in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    priority if (in_i.sequence_req < ne_q)      ack_kind_d = KIND_DUP;
    else if (diff >= SEQ_W'(WINDOW))            ack_kind_d = KIND_DROPPED;
    else if (valid_q[in_slot])                  ack_kind_d = KIND_DUP;
    else                                        ack_kind_d = KIND_STORED;
  end

  assign store_en = accept && match && (ack_kind_d == KIND_STORED);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && match) state_d = S_ACK;
      S_ACK:  if (out_free) state_d = valid_q[ne_slot] ? S_REL : S_IDLE;
      S_REL:  if (out_free) state_d = valid_q[nx_slot] ? S_REL : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready = 1'b0;
    ack_fire   = 1'b0;
    rel_fire   = 1'b0;
    unique case (state_q)
      S_IDLE: in_i.ready = 1'b1;
      S_ACK:  ack_fire   = out_free;
      S_REL:  rel_fire   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (store_en) valid_d[in_slot] = 1'b1;
    if (rel_fire) valid_d[ne_slot] = 1'b0;
  end

  assign ne_d        = rel_fire ? ne_q + SEQ_W'(1) : ne_q;
  assign out_valid_d = (out_valid_q && !out_o.ready) || ack_fire || rel_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ne_q        <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ne_q        <= ne_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload memory; read address follows the next expected slot
  always_ff @(posedge clk_i) begin
    if (store_en) mem[in_slot] <= in_i.payload;
    rd_q <= mem[ne_d[SLOT_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ack_kind_q <= ack_kind_d;
      ack_seq_q  <= in_i.sequence_req;
    end
    if (ack_fire) begin
      out_kind_q <= ack_kind_q;
      out_seq_q  <= ack_seq_q;
      out_pay_q  <= '0;
      out_last_q <= !valid_q[ne_slot];
    end else if (rel_fire) begin
      out_kind_q <= KIND_RELEASE;
      out_seq_q  <= ne_q;
      out_pay_q  <= rd_q;
      out_last_q <= !valid_q[nx_slot];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.sequence_res = out_seq_q;
  assign out_o.payload_res  = out_pay_q;
  assign out_o.last         = out_last_q;

`ifndef SYNTHESIS
  a_rel_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_fire |=> ne_q == $past(ne_q) + SEQ_W'(1))
    else $error("expected sequence did not advance on release");

  a_rel_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_fire |-> valid_q[ne_slot])
    else $error("release of an entry that is not held");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !valid_q[ne_slot])
    else $error("idle with a releasable entry held");

  a_store_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_en |-> (state_q == S_IDLE) && !valid_q[in_slot])
    else $error("store outside intake or over a held entry");
`endif

endmodule

FILE: hdl/bres_cfg.sv
// APB register file: own system id and own component id.
// Depends on bres_pkg.
module bres_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bres_pkg::APB_AW-1:0] paddr,
  input  logic [bres_pkg::APB_DW-1:0] pwdata,
  output logic [bres_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output bres_pkg::cfg_t              cfg_o
);
  import bres_pkg::*;

  logic [ID_W-1:0] own_sys_q, own_sys_d;
  logic [ID_W-1:0] own_comp_q, own_comp_d;
  reg_idx_e        idx;
  logic            wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    own_sys_d  = own_sys_q;
    own_comp_d = own_comp_q;
    if (wr_en) begin
      unique case (idx)
        REG_OWN_SYS:  own_sys_d  = pwdata[ID_W-1:0];
        REG_OWN_COMP: own_comp_d = pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OWN_SYS:  prdata = APB_DW'(own_sys_q);
      REG_OWN_COMP: prdata = APB_DW'(own_comp_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_sys_q  <= OWN_SYS_RST;
      own_comp_q <= OWN_COMP_RST;
    end else begin
      own_sys_q  <= own_sys_d;
      own_comp_q <= own_comp_d;
    end
  end

  assign cfg_o.own_sys  = own_sys_q;
  assign cfg_o.own_comp = own_comp_q;

endmodule
